### src/grid_bicubic_interp_with_gradient_macros.svh
// Assertion macros shared by the grid bicubic interpolator RTL.
`ifndef GRID_BICUBIC_INTERP_WITH_GRADIENT_MACROS_SVH
`define GRID_BICUBIC_INTERP_WITH_GRADIENT_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, clocked on clk, disabled in reset
`define GBI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define GBI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define GBI_ASSERT_IMP(lbl, ante, cons, msg)
`define GBI_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

### src/gbi_pkg.sv
// Shared types, codes and the Catmull-Rom weight function.
`default_nettype none
package gbi_pkg;

  // configuration register indexes
  localparam logic [2:0] CFG_R_ORIGIN   = 3'd0;
  localparam logic [2:0] CFG_Z_ORIGIN   = 3'd1;
  localparam logic [2:0] CFG_R_STEP_INV = 3'd2;
  localparam logic [2:0] CFG_Z_STEP_INV = 3'd3;
  localparam logic [2:0] CFG_COLS       = 3'd4;
  localparam logic [2:0] CFG_ROWS       = 3'd5;

  // operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  localparam int WGT_W = 27;

  typedef logic signed [WGT_W-1:0] wgt_t;

  typedef struct packed {
    wgt_t [3:0] w;   // value weights, Q.24
    wgt_t [3:0] dw;  // derivative weights, Q.24
  } wset_t;

  // t Q0.16, t2 = t*t, t3 = t2*t; results rounded to Q.24, ties up
  function automatic wset_t cr_weights(input logic [15:0] t, input logic [31:0] t2,
                                       input logic [47:0] t3);
    logic signed [53:0] c3, s2, s1, e0, e1, e2, e3, rw0, rw1, rw2, rw3;
    logic signed [37:0] q2, q1, one, f0, f1, f2, f3, rd0, rd1, rd2, rd3;
    wset_t ws;
    c3  = signed'({6'd0, t3});
    s2  = signed'({6'd0, t2, 16'd0});
    s1  = signed'({6'd0, t, 32'd0});
    e0  = -c3 + (s2 <<< 1) - s1;
    e1  = 54'sd3 * c3 - 54'sd5 * s2 + (54'sd2 <<< 48);
    e2  = -(54'sd3 * c3) + (s2 <<< 2) + s1;
    e3  = c3 - s2;
    rw0 = (e0 + (54'sd1 <<< 24)) >>> 25;
    rw1 = (e1 + (54'sd1 <<< 24)) >>> 25;
    rw2 = (e2 + (54'sd1 <<< 24)) >>> 25;
    rw3 = (e3 + (54'sd1 <<< 24)) >>> 25;
    q2  = signed'({6'd0, t2});
    q1  = signed'({6'd0, t, 16'd0});
    one = 38'sd1 <<< 32;
    f0  = -(38'sd3 * q2) + (q1 <<< 2) - one;
    f1  = 38'sd9 * q2 - 38'sd10 * q1;
    f2  = -(38'sd9 * q2) + (q1 <<< 3) + one;
    f3  = 38'sd3 * q2 - (q1 <<< 1);
    rd0 = (f0 + 38'sd256) >>> 9;
    rd1 = (f1 + 38'sd256) >>> 9;
    rd2 = (f2 + 38'sd256) >>> 9;
    rd3 = (f3 + 38'sd256) >>> 9;
    ws.w[0]  = rw0[WGT_W-1:0];
    ws.w[1]  = rw1[WGT_W-1:0];
    ws.w[2]  = rw2[WGT_W-1:0];
    ws.w[3]  = rw3[WGT_W-1:0];
    ws.dw[0] = rd0[WGT_W-1:0];
    ws.dw[1] = rd1[WGT_W-1:0];
    ws.dw[2] = rd2[WGT_W-1:0];
    ws.dw[3] = rd3[WGT_W-1:0];
    return ws;
  endfunction

endpackage
`default_nettype wire

### src/gbi_grid_mem.sv
// Single-port grid sample memory with a registered read.
`default_nettype none
module gbi_grid_mem #(
  parameter int DEPTH = 16384,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic          we,
  input  wire logic [AW-1:0] addr,
  input  wire logic [31:0]   wdata,
  output logic      [31:0]   rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule
`default_nettype wire

### src/grid_bicubic_interp_with_gradient.sv
// Evaluate transaction: taken only while idle; the next is accepted once the result
// is in the output register. Sixteen neighbourhood reads share the single memory port;
// per-axis locate, weight and derivative scaling steps run on shared units.
// Write transactions are taken one per cycle whenever the sequencer is idle.
// Reset (rst_n low, synchronous) clears control and loads register defaults;
// grid memory contents are not cleared and stay undefined until written.
`default_nettype none
`include "grid_bicubic_interp_with_gradient_macros.svh"
module grid_bicubic_interp_with_gradient #(
  parameter int GRID_COLS = 64,
  parameter int GRID_ROWS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration writes
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  // input transactions
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_operation,
  input  wire logic [1:0]  in_component,
  input  wire logic [11:0] in_grid_address,
  input  wire logic signed [31:0] in_grid_value,
  input  wire logic signed [31:0] in_coord_r,
  input  wire logic signed [31:0] in_coord_z,
  // result transactions
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic signed [47:0] out_interp_value,
  output logic signed [47:0] out_grad_r,
  output logic signed [47:0] out_grad_z,
  output logic             out_out_of_range
);

  localparam int TW    = GRID_COLS * GRID_ROWS;   // words per table
  localparam int DEPTH = 4 * TW;
  localparam int AW    = $clog2(DEPTH);
  localparam int CWC   = $clog2(GRID_COLS);
  localparam int CWR   = $clog2(GRID_ROWS);
  localparam int NCW   = $clog2(GRID_COLS + 1);
  localparam int NRW   = $clog2(GRID_ROWS + 1);
  localparam int RAW   = 61;   // row accumulator
  localparam int RVW   = 37;   // rounded row sum, Q.16
  localparam int CAW   = 64;   // column accumulator

  localparam logic signed [RAW-1:0] RHALF = RAW'(1) << 23;
  localparam logic signed [CAW-1:0] CHALF = CAW'(1) << 23;
  localparam logic [47:0] SAT48_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] SAT48_MIN = 48'h8000_0000_0000;

  typedef enum logic [3:0] {
    S_IDLE, S_LMUL, S_LRES, S_SQ, S_CUB, S_WGT, S_RD, S_DRAIN,
    S_FIN, S_SMUL, S_SADD, S_DONE
  } state_t;

  // read pipeline tag: which row j and column k a word belongs to
  typedef struct packed {
    logic       vld;
    logic [1:0] j;
    logic [1:0] k;
  } tag_t;

  state_t state_r, state_nxt;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [31:0] r_origin_r, z_origin_r;
  logic [31:0] r_inv_r, z_inv_r;
  logic [6:0]  cols_r, rows_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_origin_r <= '0;
      z_origin_r <= '0;
      r_inv_r    <= 32'd65536;
      z_inv_r    <= 32'd65536;
      cols_r     <= 7'd64;
      rows_r     <= 7'd64;
    end else if (cfg_we) begin
      case (cfg_index)
        gbi_pkg::CFG_R_ORIGIN:   r_origin_r <= cfg_data;
        gbi_pkg::CFG_Z_ORIGIN:   z_origin_r <= cfg_data;
        gbi_pkg::CFG_R_STEP_INV: r_inv_r    <= cfg_data;
        gbi_pkg::CFG_Z_STEP_INV: z_inv_r    <= cfg_data;
        gbi_pkg::CFG_COLS:       cols_r     <= cfg_data[6:0];
        gbi_pkg::CFG_ROWS:       rows_r     <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // used grid size, clamped to [4, GRID_*]
  logic [NCW-1:0] nc, nc_m1;
  logic [NRW-1:0] nr, nr_m1;

  always_comb begin
    if (32'(cols_r) < 32'd4) begin
      nc = NCW'(4);
    end else if (32'(cols_r) > GRID_COLS) begin
      nc = NCW'(GRID_COLS);
    end else begin
      nc = NCW'(cols_r);
    end
    if (32'(rows_r) < 32'd4) begin
      nr = NRW'(4);
    end else if (32'(rows_r) > GRID_ROWS) begin
      nr = NRW'(GRID_ROWS);
    end else begin
      nr = NRW'(rows_r);
    end
    nc_m1 = nc - NCW'(1);
    nr_m1 = nr - NRW'(1);
  end

  // ---------------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------------
  logic in_fire, eval_fire, wr_fire;

  // nothing is taken while reset is held
  assign in_ready  = rst_n && (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign eval_fire = in_fire && (in_operation == gbi_pkg::OP_EVAL);
  assign wr_fire   = in_fire && (in_operation == gbi_pkg::OP_WRITE);

  // ---------------------------------------------------------------------------
  // Sequencer control
  // ---------------------------------------------------------------------------
  logic       ax_r;      // axis being worked on: 0 = r, 1 = z
  logic [3:0] cnt_r;     // neighbourhood read index, row in [3:2], column in [1:0]
  tag_t       tg1_r, tg2_r, tg3_r, tg4_r;
  logic       v5_r;
  logic       pipe_busy;
  logic       rd_issue;

  assign pipe_busy = tg1_r.vld || tg2_r.vld || tg3_r.vld || tg4_r.vld || v5_r;
  assign rd_issue  = (state_r == S_RD);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (eval_fire) state_nxt = S_LMUL;
      S_LMUL:  state_nxt = S_LRES;
      S_LRES:  state_nxt = ax_r ? S_SQ : S_LMUL;
      S_SQ:    state_nxt = S_CUB;
      S_CUB:   state_nxt = S_WGT;
      S_WGT:   state_nxt = ax_r ? S_RD : S_SQ;
      S_RD:    if (cnt_r == 4'd15) state_nxt = S_DRAIN;
      S_DRAIN: if (!pipe_busy) state_nxt = S_FIN;
      S_FIN:   state_nxt = S_SMUL;
      S_SMUL:  state_nxt = S_SADD;
      S_SADD:  state_nxt = ax_r ? S_DONE : S_SMUL;
      S_DONE:  if (!out_valid || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // result staging: value from final rounding, gradients from the scale steps, range flag from locate
  logic signed [47:0] val_r;
  logic [47:0] g_r [2];
  logic        oor_r;

  // state and the output register; the output register frees the sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_valid <= 1'b0;
      ax_r      <= 1'b0;
      cnt_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_LRES || state_r == S_WGT || state_r == S_SADD) begin
        ax_r <= ~ax_r;
      end else if (eval_fire) begin
        ax_r <= 1'b0;
      end
      if (rd_issue) begin
        cnt_r <= cnt_r + 4'd1;
      end else begin
        cnt_r <= '0;
      end
      if (state_r == S_DONE && (!out_valid || out_ready)) begin
        out_valid        <= 1'b1;
        out_interp_value <= val_r;
        out_grad_r       <= g_r[0];
        out_grad_z       <= g_r[1];
        out_out_of_range <= oor_r;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Grid memory and neighbourhood addressing
  // ---------------------------------------------------------------------------
  logic [AW-1:0]  base_r;
  logic [CWC-1:0] cell_c_r;
  logic [CWR-1:0] cell_z_r;
  logic [CWC+1:0] colv;
  logic [CWR+1:0] rowv;
  logic [CWC-1:0] col_sel;
  logic [CWR-1:0] row_sel;
  logic [CWR+NCW-1:0] rowoff;
  logic [AW-1:0]  rd_addr, wr_addr, mem_addr;
  logic           wr_ok, mem_we, mem_re;
  logic [31:0]    mem_q;

  always_comb begin
    // neighbour indexes clamp to the grid edge
    rowv = {2'b00, cell_z_r} + (CWR+2)'(cnt_r[3:2]) - (CWR+2)'(1);
    colv = {2'b00, cell_c_r} + (CWC+2)'(cnt_r[1:0]) - (CWC+2)'(1);
    if (rowv[CWR+1]) begin
      row_sel = '0;
    end else if (32'(rowv) > 32'(nr_m1)) begin
      row_sel = nr_m1[CWR-1:0];
    end else begin
      row_sel = rowv[CWR-1:0];
    end
    if (colv[CWC+1]) begin
      col_sel = '0;
    end else if (32'(colv) > 32'(nc_m1)) begin
      col_sel = nc_m1[CWC-1:0];
    end else begin
      col_sel = colv[CWC-1:0];
    end
    rowoff  = row_sel * nc;
    rd_addr = base_r + AW'(rowoff) + AW'(col_sel);
    wr_addr = AW'(in_component) * AW'(TW) + AW'(in_grid_address);
  end

  assign wr_ok    = (32'(in_grid_address) < TW);
  assign mem_we   = wr_fire && wr_ok;
  assign mem_re   = rd_issue;
  assign mem_addr = mem_we ? wr_addr : rd_addr;

  gbi_grid_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk   (clk),
    .en    (mem_we || mem_re),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (in_grid_value),
    .rdata (mem_q)
  );

  // read pipeline tags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tg1_r <= '0;
      tg2_r <= '0;
      tg3_r <= '0;
      tg4_r <= '0;
      v5_r  <= 1'b0;
    end else begin
      tg1_r <= '{vld: rd_issue, j: cnt_r[3:2], k: cnt_r[1:0]};
      tg2_r <= tg1_r;
      tg3_r <= '{vld: tg2_r.vld && (tg2_r.k == 2'd3), j: tg2_r.j, k: tg2_r.k};
      tg4_r <= tg3_r;
      v5_r  <= tg4_r.vld;
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------------------
  logic        d_neg_r [2];
  logic [31:0] d_mag_r [2];
  logic [15:0] t_r [2];
  logic [63:0] loc_prod_r;
  logic [31:0] sq_r;
  logic [47:0] cu_r;
  gbi_pkg::wset_t wr_r, wz_r;

  logic signed [58:0] pv_r, pd_r;
  logic signed [RAW-1:0] racc_v_r, racc_d_r, rsum_v, rsum_d;
  logic signed [RVW-1:0] rv_r, rd_r;
  logic signed [63:0] cv_r, cgr_r, cgz_r;
  logic signed [CAW-1:0] vacc_r, gracc_r, gzacc_r, qv, qgr, qgz;
  logic [39:0] mag_r [2];
  logic        neg_r [2];
  logic [55:0] pa_r, pb_r;
  logic [56:0] psum;
  logic [47:0] g_new;

  logic [32:0] dr, dz;
  logic [31:0] idx, lim_sel, inv_sel;
  logic [15:0] t_sel;

  always_comb begin
    dr      = {in_coord_r[31], in_coord_r} - {r_origin_r[31], r_origin_r};
    dz      = {in_coord_z[31], in_coord_z} - {z_origin_r[31], z_origin_r};
    idx     = loc_prod_r[63:32];
    lim_sel = ax_r ? 32'(nr) : 32'(nc);
    inv_sel = ax_r ? z_inv_r : r_inv_r;
    t_sel   = t_r[ax_r];
    rsum_v  = (racc_v_r + RHALF) >>> 24;
    rsum_d  = (racc_d_r + RHALF) >>> 24;
    qv      = (vacc_r + CHALF) >>> 24;
    qgr     = (gracc_r + CHALF) >>> 24;
    qgz     = (gzacc_r + CHALF) >>> 24;
    // magnitude times inverse spacing: integer half plus rounded fraction half
    psum    = 57'(pa_r) + 57'((pb_r + 56'h8000) >> 16);
    if (psum[56:47] != '0) begin
      g_new = neg_r[ax_r] ? SAT48_MIN : SAT48_MAX;
    end else begin
      g_new = neg_r[ax_r] ? -psum[47:0] : psum[47:0];
    end
  end

  always_ff @(posedge clk) begin
    if (eval_fire) begin
      base_r     <= AW'(in_component) * AW'(TW);
      d_neg_r[0] <= dr[32];
      d_mag_r[0] <= dr[31:0];
      d_neg_r[1] <= dz[32];
      d_mag_r[1] <= dz[31:0];
      oor_r      <= 1'b0;
      vacc_r     <= '0;
      gracc_r    <= '0;
      gzacc_r    <= '0;
    end

    // locate: cell index and Q0.16 offset per axis
    if (state_r == S_LMUL) begin
      loc_prod_r <= d_mag_r[ax_r] * inv_sel;
    end
    if (state_r == S_LRES) begin
      if (d_neg_r[ax_r]) begin
        oor_r     <= 1'b1;
        t_r[ax_r] <= '0;
        if (ax_r) cell_z_r <= '0; else cell_c_r <= '0;
      end else if (idx >= lim_sel) begin
        oor_r     <= 1'b1;
        t_r[ax_r] <= 16'hFFFF;
        if (ax_r) cell_z_r <= '0; else cell_c_r <= '0;
      end else begin
        t_r[ax_r] <= loc_prod_r[31:16];
        if (ax_r) cell_z_r <= idx[CWR-1:0]; else cell_c_r <= idx[CWC-1:0];
      end
    end

    // weights
    if (state_r == S_SQ) sq_r <= t_sel * t_sel;
    if (state_r == S_CUB) cu_r <= sq_r * t_sel;
    if (state_r == S_WGT) begin
      if (ax_r) wz_r <= gbi_pkg::cr_weights(t_sel, sq_r, cu_r);
      else      wr_r <= gbi_pkg::cr_weights(t_sel, sq_r, cu_r);
    end

    // row pass
    if (tg1_r.vld) begin
      pv_r <= $signed(mem_q) * wr_r.w[tg1_r.k];
      pd_r <= $signed(mem_q) * wr_r.dw[tg1_r.k];
    end
    if (tg2_r.vld) begin
      racc_v_r <= ((tg2_r.k == 2'd0) ? '0 : racc_v_r) + RAW'(pv_r);
      racc_d_r <= ((tg2_r.k == 2'd0) ? '0 : racc_d_r) + RAW'(pd_r);
    end
    if (tg3_r.vld) begin
      rv_r <= rsum_v[RVW-1:0];
      rd_r <= rsum_d[RVW-1:0];
    end

    // column pass
    if (tg4_r.vld) begin
      cv_r  <= rv_r * wz_r.w[tg4_r.j];
      cgz_r <= rv_r * wz_r.dw[tg4_r.j];
      cgr_r <= rd_r * wz_r.w[tg4_r.j];
    end
    if (v5_r) begin
      vacc_r  <= vacc_r + cv_r;
      gracc_r <= gracc_r + cgr_r;
      gzacc_r <= gzacc_r + cgz_r;
    end

    // final rounding and derivative scaling
    if (state_r == S_FIN) begin
      val_r    <= qv[47:0];
      neg_r[0] <= qgr[CAW-1];
      mag_r[0] <= qgr[CAW-1] ? 40'(-qgr) : qgr[39:0];
      neg_r[1] <= qgz[CAW-1];
      mag_r[1] <= qgz[CAW-1] ? 40'(-qgz) : qgz[39:0];
    end
    if (state_r == S_SMUL) begin
      pa_r <= mag_r[ax_r] * inv_sel[31:16];
      pb_r <= mag_r[ax_r] * inv_sel[15:0];
    end
    if (state_r == S_SADD) begin
      g_r[ax_r] <= g_new;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `GBI_ASSERT_IMP(a_no_rw_clash, mem_we, !mem_re, "grid write collides with a read")
  `GBI_ASSERT_NXT(a_write_stays_idle, wr_fire, state_r == S_IDLE, "write left idle")
  `GBI_ASSERT_IMP(a_fin_drained, state_r == S_FIN, !pipe_busy, "finish before drain")
  `GBI_ASSERT_IMP(a_result_from_done, $rose(out_valid), $past(state_r) == S_DONE,
                  "result without a finished evaluate")

endmodule
`default_nettype wire

### verif/grid_bicubic_interp_with_gradient_test.sv
// Self-checking testbench for the grid bicubic interpolator with gradients.
`timescale 1ns / 100ps
`default_nettype none
module grid_bicubic_interp_with_gradient_test;

  localparam int TABLE_WORDS = 64 * 64;
  localparam longint SAT_MAX = 64'sh7FFF_FFFF_FFFF;
  localparam longint SAT_MIN = -SAT_MAX - 1;

  // one expected result transaction
  typedef struct {
    logic signed [47:0] value;
    logic signed [47:0] gr;
    logic signed [47:0] gz;
    logic               oor;
  } interp_res_t;

  // one row of the directed table; typed rows carry their own expected result
  typedef struct {
    logic        op;
    logic [1:0]  comp;
    logic [11:0] addr;
    logic [31:0] val;
    logic [31:0] cr;
    logic [31:0] cz;
    bit          typed;
    interp_res_t want;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic in_operation;
  logic [1:0] in_component;
  logic [11:0] in_grid_address;
  logic signed [31:0] in_grid_value;
  logic signed [31:0] in_coord_r;
  logic signed [31:0] in_coord_z;
  logic out_valid;
  logic out_ready;
  logic signed [47:0] out_interp_value;
  logic signed [47:0] out_grad_r;
  logic signed [47:0] out_grad_z;
  logic out_out_of_range;

  grid_bicubic_interp_with_gradient dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_operation(in_operation), .in_component(in_component),
    .in_grid_address(in_grid_address), .in_grid_value(in_grid_value),
    .in_coord_r(in_coord_r), .in_coord_z(in_coord_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_interp_value(out_interp_value), .out_grad_r(out_grad_r),
    .out_grad_z(out_grad_z), .out_out_of_range(out_out_of_range)
  );

  // mirror of the grid tables and registers
  logic [31:0] grid_mirror [0:4*TABLE_WORDS-1];
  bit          written [0:4*TABLE_WORDS-1];
  logic [31:0] r_org, z_org, r_inv, z_inv;
  logic [6:0]  cols_reg, rows_reg;

  interp_res_t pending_q[$];
  int err_cnt = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit hold_now = 0;
  dir_row_t dir_tab[$];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // hard limit, far beyond the slowest legal run
  initial begin
    #(64'd30_000_000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------- predictor ----------------

  function automatic longint round_sh(longint x, int sh);
    return (x + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint sat_48(longint x);
    if (x > SAT_MAX) return SAT_MAX;
    if (x < SAT_MIN) return SAT_MIN;
    return x;
  endfunction

  function automatic int used_count(logic [6:0] r);
    if (r < 4) return 4;
    if (r > 64) return 64;
    return int'(r);
  endfunction

  // cell and Q0.16 offset along one axis; returns 1 when outside the grid
  function automatic bit locate_axis(logic [31:0] coord, logic [31:0] origin,
                                     logic [31:0] inv, int n,
                                     output int cell_ix, output longint t);
    longint d;
    logic [63:0] u, lo, idx;
    d = longint'(signed'(coord)) - longint'(signed'(origin));
    if (d < 0) begin
      cell_ix = 0; t = 0;
      return 1'b1;
    end
    u = d;
    lo = {32'd0, u[31:0]} * {32'd0, inv};
    idx = (u >> 32) * {32'd0, inv} + (lo >> 32);
    if (idx >= n) begin
      cell_ix = 0; t = 16'hFFFF;
      return 1'b1;
    end
    cell_ix = int'(idx);
    t = longint'(lo[31:16]);
    return 1'b0;
  endfunction

  function automatic void cr_wts(longint t, output longint w[4], output longint dw[4]);
    longint t2, t3, t2s, ts, tq, one;
    t2 = t * t; t3 = t2 * t;
    t2s = t2 * 65536; ts = t * (64'sd1 <<< 32);
    tq = t * 65536; one = 64'sd1 <<< 32;
    w[0] = round_sh(-t3 + 2 * t2s - ts, 25);
    w[1] = round_sh(3 * t3 - 5 * t2s + (64'sd2 <<< 48), 25);
    w[2] = round_sh(-3 * t3 + 4 * t2s + ts, 25);
    w[3] = round_sh(t3 - t2s, 25);
    dw[0] = round_sh(-3 * t2 + 4 * tq - one, 9);
    dw[1] = round_sh(9 * t2 - 10 * tq, 9);
    dw[2] = round_sh(-9 * t2 + 8 * tq + one, 9);
    dw[3] = round_sh(3 * t2 - 2 * tq, 9);
  endfunction

  // derivative times inverse spacing, magnitude rounded half away from zero
  function automatic longint scale_grad(longint d, logic [31:0] inv);
    bit neg;
    logic [63:0] mag, p;
    longint m;
    neg = d < 0;
    mag = neg ? -d : d;
    p = mag * {48'd0, inv[31:16]} + ((mag * {48'd0, inv[15:0]} + 64'h8000) >> 16);
    if (p > 64'h8000_0000_0000) p = 64'h8000_0000_0000;
    m = longint'(p);
    return sat_48(neg ? -m : m);
  endfunction

  function automatic int clamp_ix(int v, int n);
    if (v < 0) return 0;
    if (v > n - 1) return n - 1;
    return v;
  endfunction

  function automatic interp_res_t predict_interp(logic [1:0] comp, logic [31:0] cr,
                                                 logic [31:0] cz);
    interp_res_t res;
    int nc, nr, ir, iz, row, col, base;
    longint tr, tz, s, rv, rd, v, gr, gz;
    longint wr[4], dwr[4], wz[4], dwz[4];
    bit oor;
    nc = used_count(cols_reg);
    nr = used_count(rows_reg);
    base = int'(comp) * TABLE_WORDS;
    oor = locate_axis(cr, r_org, r_inv, nc, ir, tr);
    oor = locate_axis(cz, z_org, z_inv, nr, iz, tz) | oor;
    cr_wts(tr, wr, dwr);
    cr_wts(tz, wz, dwz);
    v = 0; gr = 0; gz = 0;
    for (int j = 0; j < 4; j++) begin
      row = clamp_ix(iz + j - 1, nr);
      rv = 0; rd = 0;
      for (int k = 0; k < 4; k++) begin
        col = clamp_ix(ir + k - 1, nc);
        s = longint'(signed'(grid_mirror[base + row * nc + col]));
        rv += s * wr[k];
        rd += s * dwr[k];
      end
      rv = round_sh(rv, 24);
      rd = round_sh(rd, 24);
      v += rv * wz[j];
      gz += rv * dwz[j];
      gr += rd * wz[j];
    end
    res.value = 48'(sat_48(round_sh(v, 24)));
    res.gr = 48'(scale_grad(round_sh(gr, 24), r_inv));
    res.gz = 48'(scale_grad(round_sh(gz, 24), z_inv));
    res.oor = oor;
    return res;
  endfunction

  // first word of the evaluate's neighbourhood never written, or -1
  function automatic int first_gap(logic [1:0] comp, logic [31:0] cr, logic [31:0] cz);
    int nc, nr, ir, iz, row, col, base;
    longint tr, tz;
    nc = used_count(cols_reg);
    nr = used_count(rows_reg);
    base = int'(comp) * TABLE_WORDS;
    void'(locate_axis(cr, r_org, r_inv, nc, ir, tr));
    void'(locate_axis(cz, z_org, z_inv, nr, iz, tz));
    for (int j = 0; j < 4; j++) begin
      row = clamp_ix(iz + j - 1, nr);
      for (int k = 0; k < 4; k++) begin
        col = clamp_ix(ir + k - 1, nc);
        if (!written[base + row * nc + col]) return row * nc + col;
      end
    end
    return -1;
  endfunction

  // ---------------- driving ----------------

  // offer one transaction, hold it until accepted, then record what it implies
  task automatic send_txn(logic op, logic [1:0] comp, logic [11:0] addr, logic [31:0] val,
                          logic [31:0] cr, logic [31:0] cz, bit typed, interp_res_t want);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < tx_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_component <= comp;
    in_grid_address <= addr;
    in_grid_value <= val;
    in_coord_r <= cr;
    in_coord_z <= cz;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op == gbi_pkg::OP_WRITE) begin
      grid_mirror[int'(comp) * TABLE_WORDS + int'(addr)] = val;
      written[int'(comp) * TABLE_WORDS + int'(addr)] = 1'b1;
    end else begin
      pending_q.push_back(typed ? want : predict_interp(comp, cr, cz));
    end
  endtask

  // wait for the pipe to drain, then write every register
  task automatic load_regs(logic [31:0] ro, logic [31:0] zo, logic [31:0] ri,
                           logic [31:0] zi, logic [6:0] nc, logic [6:0] nr);
    logic [31:0] vals [6];
    logic [2:0]  regs [6];
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    vals = '{ro, zo, ri, zi, {25'd0, nc}, {25'd0, nr}};
    regs = '{gbi_pkg::CFG_R_ORIGIN, gbi_pkg::CFG_Z_ORIGIN, gbi_pkg::CFG_R_STEP_INV,
             gbi_pkg::CFG_Z_STEP_INV, gbi_pkg::CFG_COLS, gbi_pkg::CFG_ROWS};
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= regs[i];
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    r_org = ro; z_org = zo; r_inv = ri; z_inv = zi;
    cols_reg = nc; rows_reg = nr;
  endtask

  // point for an evaluate: mostly in the first cells, some anywhere inside,
  // some on the far edge, some just below the grid, some anywhere at all
  function automatic logic [31:0] pick_coord(logic [31:0] origin, logic [31:0] inv,
                                             logic [6:0] n_reg);
    longint span, win, d;
    int sel;
    if (inv == 0) span = 64'sd1 <<< 31;
    else span = (longint'(used_count(n_reg)) <<< 32) / longint'(inv);
    if (span > 64'sh0FFFF_FFFF) span = 64'sh0FFFF_FFFF;
    if (span < 1) span = 1;
    win = span * 6 / longint'(used_count(n_reg));
    if (win < 1) win = 1;
    sel = $urandom_range(99);
    if (sel < 20) d = longint'($urandom) % span;
    else if (sel < 70) d = longint'($urandom) % win;
    else if (sel < 80) return $urandom;
    else if (sel < 90) d = span - 2 + $urandom_range(0, 3);
    else d = -longint'($urandom_range(0, 2));
    return origin + d[31:0];
  endfunction

  // count covers the writes that fill an evaluate's unwritten neighbours
  task automatic random_items(int count);
    logic [1:0] comp;
    logic [31:0] cr, cz;
    int gap, sent;
    interp_res_t none;
    none = '{0, 0, 0, 0};
    sent = 0;
    while (sent < count) begin
      comp = 2'($urandom_range(3));
      if ($urandom_range(99) < 35) begin
        send_txn(gbi_pkg::OP_WRITE, comp, 12'($urandom), $urandom, $urandom, $urandom,
                 1'b0, none);
      end else begin
        cr = pick_coord(r_org, r_inv, cols_reg);
        cz = pick_coord(z_org, z_inv, rows_reg);
        gap = first_gap(comp, cr, cz);
        while (gap >= 0) begin
          send_txn(gbi_pkg::OP_WRITE, comp, 12'(gap), $urandom, $urandom, $urandom,
                   1'b0, none);
          sent++;
          gap = first_gap(comp, cr, cz);
        end
        send_txn(gbi_pkg::OP_EVAL, comp, 12'($urandom), $urandom, cr, cz, 1'b0, none);
      end
      sent++;
    end
  endtask

  // receiver: random ready, with a long hold-off on request
  initial begin
    int hold_cnt;
    hold_cnt = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_now) begin
        hold_now = 0;
        hold_cnt = 600;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // ---------------- checking ----------------

  task automatic flag_mismatch(string what, logic [47:0] want, logic [47:0] got);
    err_cnt++;
    if (err_cnt <= 10)
      $display("mismatch %s: expected %h got %h at %0t", what, want, got, $realtime);
  endtask

  always @(posedge clk) begin
    interp_res_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        flag_mismatch("unexpected result transaction", 48'd0, out_interp_value);
      end else begin
        e = pending_q.pop_front();
        if (out_interp_value !== e.value) flag_mismatch("interp_value", e.value, out_interp_value);
        if (out_grad_r !== e.gr) flag_mismatch("grad_r", e.gr, out_grad_r);
        if (out_grad_z !== e.gz) flag_mismatch("grad_z", e.gz, out_grad_z);
        if (out_out_of_range !== e.oor)
          flag_mismatch("out_of_range", {47'd0, e.oor}, {47'd0, out_out_of_range});
      end
    end
  end

  // ---------------- sequence ----------------

  initial begin
    interp_res_t none, minval_in, minval_out;
    none = '{0, 0, 0, 0};
    // a 3x3 patch of the most negative sample makes the value exact, slopes zero
    minval_in = '{48'shFFFF_8000_0000, 0, 0, 1'b0};
    minval_out = '{48'shFFFF_8000_0000, 0, 0, 1'b1};
    rst_n <= 1'b0;
    cfg_we <= 1'b0; cfg_index <= '0; cfg_data <= '0;
    in_valid <= 1'b0; in_operation <= gbi_pkg::OP_WRITE; in_component <= '0;
    in_grid_address <= '0; in_grid_value <= '0; in_coord_r <= '0; in_coord_z <= '0;
    r_org = 0; z_org = 0; r_inv = 32'h10000; z_inv = 32'h10000;
    cols_reg = 7'd64; rows_reg = 7'd64;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, reset register values
    for (int a = 0; a < 3; a++)
      for (int b = 0; b < 3; b++)
        dir_tab.push_back('{gbi_pkg::OP_WRITE, 2'd3, 12'(a * 64 + b), 32'h8000_0000,
                            0, 0, 0, none});
    dir_tab.push_back('{gbi_pkg::OP_EVAL, 2'd3, 0, 0, 32'h0, 32'h0, 1, minval_in});
    dir_tab.push_back('{gbi_pkg::OP_EVAL, 2'd3, 0, 0, 32'hFFFF_FFFF, 32'h0, 1, minval_out});
    dir_tab.push_back('{gbi_pkg::OP_EVAL, 2'd3, 0, 0, 32'h0, 32'h8000_0000, 1, minval_out});
    dir_tab.push_back('{gbi_pkg::OP_EVAL, 2'd3, 0, 0, 32'h7FFF_FFFF, 32'h0, 0, none});
    dir_tab.push_back('{gbi_pkg::OP_EVAL, 2'd3, 0, 0, 32'h0040_0000, 32'h0000_FFFF, 0, none});
    dir_tab.push_back('{gbi_pkg::OP_WRITE, 2'd0, 12'hFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                        32'hFFFF_FFFF, 0, none});
    dir_tab.push_back('{gbi_pkg::OP_WRITE, 2'd1, 12'h000, 32'h0, 0, 0, 0, none});
    dir_tab.push_back('{gbi_pkg::OP_WRITE, 2'd2, 12'h800, 32'h8000_0000, 0, 0, 0, none});
    dir_tab.push_back('{gbi_pkg::OP_EVAL, 2'd3, 12'hFFF, 32'hFFFF_FFFF, 32'h0000_8000,
                        32'h0000_8000, 0, none});
    dir_tab.push_back('{gbi_pkg::OP_EVAL, 2'd3, 0, 0, 32'h0000_FFFF, 32'h0000_FFFF, 0, none});
    foreach (dir_tab[i])
      send_txn(dir_tab[i].op, dir_tab[i].comp, dir_tab[i].addr, dir_tab[i].val,
               dir_tab[i].cr, dir_tab[i].cz, dir_tab[i].typed, dir_tab[i].want);

    // phase 1: slow sender side light, receiver stalls heavily
    tx_idle_pct = 37; rx_idle_pct = 83;
    load_regs(0, 0, 32'h10000, 32'h10000, 7'd64, 7'd64);
    random_items(280);
    load_regs(32'h8000_0000, 32'h7FFF_0000, 32'hFFFF_FFFF, 32'h0, 7'd4, 7'd127);
    random_items(280);

    // phase 2: roles swapped
    tx_idle_pct = 83; rx_idle_pct = 37;
    load_regs(32'hFFFD_0000, $urandom, 32'h20000, 32'h8000, 7'd0, 7'd4);
    random_items(280);
    load_regs($urandom, $urandom, $urandom, $urandom, 7'($urandom_range(0, 127)),
              7'($urandom_range(0, 127)));
    random_items(280);

    // phase 3: no idling, with one long receiver hold-off to back up the block
    tx_idle_pct = 0; rx_idle_pct = 0;
    load_regs(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 7'd64, 7'd17);
    hold_now = 1;
    random_items(280);
    load_regs($urandom, $urandom, $urandom_range(32'h4000, 32'h40000),
              $urandom_range(32'h4000, 32'h40000), 7'($urandom_range(4, 64)),
              7'($urandom_range(4, 64)));
    random_items(280);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire
